@@ design/sbfd_pkg.sv @@
// Shared types, constants and the saturating adder of the stereo feedback delay.
package sbfd_pkg;

  localparam int SAMPLE_BITS      = 24;
  localparam int CFG_W            = 11;
  localparam int DEF_BLOCK_SIZE   = 64;
  localparam int DEF_MAX_BLOCKS   = 1024;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t sample_left;
    sample_t sample_right;
    sample_t feedback_left;
    sample_t feedback_right;
  } in_item_t;

  typedef struct packed {
    sample_t delayed_left;
    sample_t delayed_right;
    logic    block_last;
  } out_item_t;

  // Per-item flags from the address sequencer to the datapath.
  typedef struct packed {
    logic last;    // last sample of its block
    logic fwd;     // read and write hit the same entry
    logic filled;  // read entry has been written since reset
  } ctrl_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  function automatic sample_t sat_add(input sample_t a, input sample_t b);
    logic signed [SAMPLE_BITS:0] sum;
    sample_t res;
    sum = {a[SAMPLE_BITS-1], a} + {b[SAMPLE_BITS-1], b};
    if (sum[SAMPLE_BITS] != sum[SAMPLE_BITS-1]) begin
      res = sum[SAMPLE_BITS] ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      res = sum[SAMPLE_BITS-1:0];
    end
    return res;
  endfunction

endpackage

@@ design/sbfd_store.sv @@
// One circular sample store: single write port, single read port, registered read.
module sbfd_store import sbfd_pkg::*; #(
  parameter int WIDTH = SAMPLE_BITS,
  parameter int DEPTH = DEF_BLOCK_SIZE * DEF_MAX_BLOCKS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] store_mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      store_mem[waddr_i] <= wdata_i;
    end
  end

  // Old data on a same-address collision; the datapath forwards around it.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= store_mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/sbfd_addr.sv @@
// Write/read pointer sequencer, delay length register and store fill count.
module sbfd_addr import sbfd_pkg::*; #(
  parameter int BLOCK_SIZE = DEF_BLOCK_SIZE,
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int DEPTH      = BLOCK_SIZE * MAX_BLOCKS,
  parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output logic [AW-1:0]    wr_addr_o,
  output logic [AW-1:0]    rd_addr_o,
  output ctrl_t            ctrl_o
);

  localparam int LW  = $clog2(DEPTH + 1);
  localparam int OW  = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
  localparam int MBW = $clog2(MAX_BLOCKS + 1);
  localparam int CW  = (CFG_W > MBW) ? CFG_W : MBW;

  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] fill_q, fill_d;
  logic [AW-1:0] wr_q, wr_d;
  logic [AW-1:0] rd_q, rd_d;
  logic [AW-1:0] nxt_q, nxt_d;
  logic [OW-1:0] off_q, off_d;

  logic [CW-1:0] blocks_raw;
  logic [CW-1:0] blocks_c;
  logic [LW:0]   nxt_sum;
  logic [AW-1:0] nxt_roll;
  logic          last;

  assign last = (off_q == OW'(BLOCK_SIZE - 1));

  always_comb begin
    blocks_raw = CW'(cfg_data_i);
    if (blocks_raw == '0) begin
      blocks_c = CW'(1);
    end else if (blocks_raw > CW'(MAX_BLOCKS)) begin
      blocks_c = CW'(MAX_BLOCKS);
    end else begin
      blocks_c = blocks_raw;
    end
  end

  // Start of the block after the next one, wrapped at the end of the delay.
  assign nxt_sum  = (LW+1)'(nxt_q) + (LW+1)'(BLOCK_SIZE);
  assign nxt_roll = (nxt_sum >= (LW+1)'(len_q)) ? '0 : AW'(nxt_sum);

  always_comb begin
    len_d  = len_q;
    fill_d = fill_q;
    wr_d   = wr_q;
    rd_d   = rd_q;
    nxt_d  = nxt_q;
    off_d  = off_q;
    if (cfg_we_i) begin
      len_d = LW'(blocks_c * BLOCK_SIZE);
      wr_d  = '0;
      off_d = '0;
      nxt_d = (blocks_c == CW'(1)) ? '0 : AW'(BLOCK_SIZE);
      rd_d  = nxt_d;
    end else if (adv_i) begin
      // Writes always run upward from zero, so the written set is a prefix.
      if (LW'(wr_q) == fill_q) begin
        fill_d = fill_q + LW'(1);
      end
      if (last) begin
        off_d = '0;
        wr_d  = nxt_q;
        nxt_d = nxt_roll;
        rd_d  = nxt_roll;
      end else begin
        off_d = off_q + OW'(1);
        wr_d  = wr_q + AW'(1);
        rd_d  = rd_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LW'(BLOCK_SIZE);
      fill_q <= '0;
      wr_q   <= '0;
      rd_q   <= '0;
      nxt_q  <= '0;
      off_q  <= '0;
    end else begin
      len_q  <= len_d;
      fill_q <= fill_d;
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      nxt_q  <= nxt_d;
      off_q  <= off_d;
    end
  end

  assign wr_addr_o     = wr_q;
  assign rd_addr_o     = rd_q;
  assign ctrl_o.last   = last;
  assign ctrl_o.fwd    = (rd_q == wr_q);
  assign ctrl_o.filled = (LW'(rd_q) < fill_q);

endmodule

@@ design/stereo_block_feedback_delay.sv @@
// Top level of the stereo block feedback delay line.
//
// Input channel (in_valid_i/in_ready_o, in_item_i): one stereo sample plus
// one feedback sample per side. The saturated sum is written to the stores.
// Output channel (out_valid_o/out_ready_i, out_item_o): one result per input
// transfer, in order: the oldest stored sample at the same block offset, and
// a flag on the last sample of each block.
// Config channel (cfg_valid_i/cfg_ready_o, cfg_data_i): delay length in whole
// blocks, clamped to 1..MAX_BLOCKS; a write restarts the write position. Write
// it only while no result is outstanding.
// A result passes through the read stage and then the output register after
// its input transfer; throughput is one item per cycle while the receiver
// does not stall, set by the one write and one read port of each store, which
// are both used by every item.
// Reset sets the delay to one block and the position to zero. The stores are
// not swept: a fill count marks the written prefix and unwritten entries read
// as zero, so items are taken right after reset.
// When the receiver stalls, the output register holds the result and one
// more item is taken into the read stage; then in_ready_o drops.
module stereo_block_feedback_delay import sbfd_pkg::*; #(
  parameter int BLOCK_SIZE = DEF_BLOCK_SIZE,
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_item_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int DEPTH = BLOCK_SIZE * MAX_BLOCKS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          accept;
  logic          cfg_we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  ctrl_t         ctrl;
  sample_t       wdata_l, wdata_r;
  logic [SAMPLE_BITS-1:0] rdata_l, rdata_r;

  logic      s1_valid_q, s1_valid_d;
  ctrl_t     s1_ctrl_q;
  sample_t   s1_fwd_l_q, s1_fwd_r_q;
  logic      s1_adv;
  out_item_t s1_item;

  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i & in_ready_o;

  assign wdata_l = sat_add(in_item_i.sample_left,  in_item_i.feedback_left);
  assign wdata_r = sat_add(in_item_i.sample_right, in_item_i.feedback_right);

  sbfd_addr #(
    .BLOCK_SIZE(BLOCK_SIZE),
    .MAX_BLOCKS(MAX_BLOCKS),
    .DEPTH     (DEPTH),
    .AW        (AW)
  ) u_addr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (accept),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data_i),
    .wr_addr_o (wr_addr),
    .rd_addr_o (rd_addr),
    .ctrl_o    (ctrl)
  );

  sbfd_store #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store_left (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(wr_addr),
    .wdata_i(wdata_l),
    .re_i   (accept),
    .raddr_i(rd_addr),
    .rdata_o(rdata_l)
  );

  sbfd_store #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store_right (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(wr_addr),
    .wdata_i(wdata_r),
    .re_i   (accept),
    .raddr_i(rd_addr),
    .rdata_o(rdata_r)
  );

  // Read stage: payload loads only on a transfer, so it holds while stalled.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctrl_q  <= ctrl;
      s1_fwd_l_q <= wdata_l;
      s1_fwd_r_q <= wdata_r;
    end
  end

  always_comb begin
    s1_item.block_last = s1_ctrl_q.last;
    if (s1_ctrl_q.fwd) begin
      s1_item.delayed_left  = s1_fwd_l_q;
      s1_item.delayed_right = s1_fwd_r_q;
    end else if (s1_ctrl_q.filled) begin
      s1_item.delayed_left  = sample_t'(rdata_l);
      s1_item.delayed_right = sample_t'(rdata_r);
    end else begin
      s1_item.delayed_left  = '0;
      s1_item.delayed_right = '0;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_valid_q && s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      out_item_q <= s1_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Input is held off only while both stages are full and the output stalls.
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input held off without a full, stalled pipeline");

  // Every input transfer lands in the read stage on the next cycle.
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted item lost before the read stage");

  // A waiting read-stage item keeps its flags until it moves on.
  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_ctrl_q)))
    else $error("read stage changed while stalled");

endmodule
